@@ design/mbs_pkg.sv @@
// Shared types, constants and codes for the mesh bounds and sphere block.
package mbs_pkg;

  localparam int COORD_BITS   = 24;
  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int RADIUS_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int DIST_BITS    = 2 * RADIUS_BITS;
  localparam int SQRT_STEPS   = RADIUS_BITS;
  localparam int STEP_BITS    = $clog2(SQRT_STEPS);
  localparam int REM_BITS     = RADIUS_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CENTER,
    S_READ,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_CMP,
    S_ROOT_GO,
    S_ROOT
  } state_t;

  // Control word for the shared distance unit
  typedef struct packed {
    logic clr_best;
    logic clr_acc;
    logic diff_en;
    logic mul_en;
    logic acc_en;
    logic cmp_en;
  } dist_ctrl_t;

endpackage

@@ design/mbs_dist.sv @@
// Shared squared-distance unit: one axis difference, one square, one add per step.
module mbs_dist (
  input  logic                        clk,
  input  mbs_pkg::vertex_t            vtx,
  input  mbs_pkg::vertex_t            center,
  input  mbs_pkg::axis_t              ax,
  input  mbs_pkg::dist_ctrl_t         ctrl,
  output logic [mbs_pkg::DIST_BITS-1:0] best
);
  import mbs_pkg::*;

  coord_t                  vsel;
  coord_t                  csel;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0]   absd_next;
  logic [COORD_BITS-1:0]   absd;
  logic [SQ_BITS-1:0]      sq;
  logic [DIST_BITS-1:0]    dacc;

  always_comb begin
    unique case (ax)
      AX_X: begin
        vsel = vtx.x;
        csel = center.x;
      end
      AX_Y: begin
        vsel = vtx.y;
        csel = center.y;
      end
      AX_Z: begin
        vsel = vtx.z;
        csel = center.z;
      end
      default: begin
        vsel = vtx.x;
        csel = center.x;
      end
    endcase
    diff = {vsel[COORD_BITS-1], vsel} - {csel[COORD_BITS-1], csel};
    // |diff| < 2^COORD_BITS since both operands are in coordinate range
    absd_next = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      absd <= absd_next;
    end
    if (ctrl.mul_en) begin
      sq <= SQ_BITS'(absd) * SQ_BITS'(absd);
    end
    if (ctrl.clr_acc) begin
      dacc <= '0;
    end else if (ctrl.acc_en) begin
      dacc <= dacc + DIST_BITS'(sq);
    end
    if (ctrl.clr_best) begin
      best <= '0;
    end else if (ctrl.cmp_en && (dacc > best)) begin
      best <= dacc;
    end
  end

endmodule

@@ design/mbs_isqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
module mbs_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbs_pkg::DIST_BITS-1:0] radicand,
  output logic                          done,
  output logic [mbs_pkg::RADIUS_BITS-1:0] root
);
  import mbs_pkg::*;

  logic                   running;
  logic [STEP_BITS-1:0]   step;
  logic [DIST_BITS-1:0]   nsh;
  logic [REM_BITS-1:0]    rem;
  logic [REM_BITS-1:0]    rem_sh;
  logic [REM_BITS-1:0]    trial;
  logic                   fits;

  always_comb begin
    rem_sh = {rem[REM_BITS-3:0], nsh[DIST_BITS-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (step == STEP_BITS'(SQRT_STEPS - 1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= radicand;
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (running) begin
      nsh  <= {nsh[DIST_BITS-3:0], 2'b00};
      step <= step + 1'b1;
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[RADIUS_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RADIUS_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/mesh_bounds_and_sphere_top.sv @@
// Top level: vertex store, box tracking, walk sequencer and result registers.
// Usage
//   Vertices arrive on x_coord/y_coord/z_coord (signed Q12.12) with
//   last_vertex marking the final vertex of a mesh. An item is taken on a
//   clock edge where start is high and busy is low.
//   For an ordinary vertex the vertex is written to the on-chip store
//   (while it has room) and the per-axis min/max registers are updated;
//   busy stays low, so a new vertex can be given every cycle.
//   On the item with last_vertex set and no overflow, busy rises. The
//   block forms the center, then walks the store: for each stored vertex
//   a read step, a difference, square and add step per axis through the
//   single shared subtract/square/accumulate unit, and a compare step.
//   A floor square root of the largest squared distance then gives the
//   radius.
//   The result appears for exactly one cycle with done high and busy low;
//   the receiver cannot stall it, so it must capture the ports on that cycle.
//   If more than MAX_VERTICES vertices come in, the last item gives done
//   on the following cycle with status 1 and all other fields zero, no walk.
//   Synchronous reset (rst) empties the mesh: count, overflow flag and box
//   clear, the sequencer returns to idle. No memory clearing is needed.
module mesh_bounds_and_sphere_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mbs_pkg::coord_t                 x_coord,
  input  mbs_pkg::coord_t                 y_coord,
  input  mbs_pkg::coord_t                 z_coord,
  input  logic                            last_vertex,
  output logic                            done,
  output logic                            status,
  output mbs_pkg::coord_t                 min_x,
  output mbs_pkg::coord_t                 min_y,
  output mbs_pkg::coord_t                 min_z,
  output mbs_pkg::coord_t                 max_x,
  output mbs_pkg::coord_t                 max_y,
  output mbs_pkg::coord_t                 max_z,
  output mbs_pkg::coord_t                 center_x,
  output mbs_pkg::coord_t                 center_y,
  output mbs_pkg::coord_t                 center_z,
  output logic [mbs_pkg::RADIUS_BITS-1:0] sphere_radius
);
  import mbs_pkg::*;

  // Sequencer
  state_t  state;
  state_t  state_next;

  // Mesh state
  logic [CNT_BITS-1:0]  vertex_count;
  logic                 overflow_seen;
  vertex_t              box_min;
  vertex_t              box_max;
  vertex_t              center;

  // Walk state
  logic [ADDR_BITS-1:0] rd_idx;
  axis_t                ax;
  axis_t                ax_next;
  vertex_t              rd_data;
  vertex_t              in_vtx;
  vertex_t              vmem [MAX_VERTICES];

  logic                 accept;
  logic                 store_full;
  logic                 ovf_now;
  logic                 first;
  logic                 walk_end;
  logic                 root_done;
  logic                 done_root_w;

  dist_ctrl_t           dctrl;
  logic                 sq_start;
  logic [DIST_BITS-1:0] best;
  logic [RADIUS_BITS-1:0] root;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign store_full = (vertex_count == CNT_BITS'(MAX_VERTICES));
  // Mesh already overflowed, or this item will find the store full
  assign ovf_now    = overflow_seen || store_full;
  assign first      = (vertex_count == '0) && !overflow_seen;
  assign walk_end   = ((CNT_BITS'(rd_idx) + 1'b1) == vertex_count);
  assign root_done  = (state == S_ROOT) && done_root_w;
  assign in_vtx     = '{x: x_coord, y: y_coord, z: z_coord};

  // Vertex store: one write port for loading, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (accept && !ovf_now) begin
      vmem[vertex_count[ADDR_BITS-1:0]] <= in_vtx;
    end
    rd_data <= vmem[rd_idx];
  end

  // Count, overflow flag and box; a result in either form empties the mesh
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      overflow_seen <= 1'b0;
      box_min       <= '0;
      box_max       <= '0;
    end else if (accept && last_vertex && ovf_now) begin
      vertex_count  <= '0;
      overflow_seen <= 1'b0;
      box_min       <= '0;
      box_max       <= '0;
    end else if (accept) begin
      if (first || (x_coord < box_min.x)) box_min.x <= x_coord;
      if (first || (y_coord < box_min.y)) box_min.y <= y_coord;
      if (first || (z_coord < box_min.z)) box_min.z <= z_coord;
      if (first || (x_coord > box_max.x)) box_max.x <= x_coord;
      if (first || (y_coord > box_max.y)) box_max.y <= y_coord;
      if (first || (z_coord > box_max.z)) box_max.z <= z_coord;
      if (ovf_now) begin
        overflow_seen <= 1'b1;
      end else begin
        vertex_count <= vertex_count + 1'b1;
      end
    end else if (root_done) begin
      vertex_count  <= '0;
      overflow_seen <= 1'b0;
      box_min       <= '0;
      box_max       <= '0;
    end
  end

  // Axis step
  always_comb begin
    unique case (ax)
      AX_X:    ax_next = AX_Y;
      AX_Y:    ax_next = AX_Z;
      AX_Z:    ax_next = AX_X;
      default: ax_next = AX_X;
    endcase
  end

  // Center and walk pointers
  always_ff @(posedge clk) begin
    unique case (state)
      S_CENTER: begin
        // floor((min+max)/2): widened sum shifted right, cut to coord width
        center.x <= coord_t'(({box_min.x[COORD_BITS-1], box_min.x}
                            + {box_max.x[COORD_BITS-1], box_max.x}) >> 1);
        center.y <= coord_t'(({box_min.y[COORD_BITS-1], box_min.y}
                            + {box_max.y[COORD_BITS-1], box_max.y}) >> 1);
        center.z <= coord_t'(({box_min.z[COORD_BITS-1], box_min.z}
                            + {box_max.z[COORD_BITS-1], box_max.z}) >> 1);
        rd_idx   <= '0;
      end
      S_READ: ax     <= AX_X;
      S_ACC:  ax     <= ax_next;
      S_CMP:  rd_idx <= rd_idx + 1'b1;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept && last_vertex && !ovf_now) state_next = S_CENTER;
      S_CENTER:  state_next = S_READ;
      S_READ:    state_next = S_DIFF;
      S_DIFF:    state_next = S_MUL;
      S_MUL:     state_next = S_ACC;
      S_ACC:     state_next = (ax == AX_Z) ? S_CMP : S_DIFF;
      S_CMP:     state_next = walk_end ? S_ROOT_GO : S_READ;
      S_ROOT_GO: state_next = S_ROOT;
      S_ROOT:    if (done_root_w) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    dctrl    = '0;
    sq_start = 1'b0;
    unique case (state)
      S_CENTER:  dctrl.clr_best = 1'b1;
      S_READ:    dctrl.clr_acc  = 1'b1;
      S_DIFF:    dctrl.diff_en  = 1'b1;
      S_MUL:     dctrl.mul_en   = 1'b1;
      S_ACC:     dctrl.acc_en   = 1'b1;
      S_CMP:     dctrl.cmp_en   = 1'b1;
      S_ROOT_GO: sq_start       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  mbs_dist u_dist (
    .clk    (clk),
    .vtx    (rd_data),
    .center (center),
    .ax     (ax),
    .ctrl   (dctrl),
    .best   (best)
  );

  mbs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (best),
    .done     (done_root_w),
    .root     (root)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && last_vertex && ovf_now) || root_done;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && last_vertex && ovf_now) begin
      status        <= 1'b1;
      min_x         <= '0;
      min_y         <= '0;
      min_z         <= '0;
      max_x         <= '0;
      max_y         <= '0;
      max_z         <= '0;
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= '0;
    end else if (root_done) begin
      status        <= 1'b0;
      min_x         <= box_min.x;
      min_y         <= box_min.y;
      min_z         <= box_min.z;
      max_x         <= box_max.x;
      max_y         <= box_max.y;
      max_z         <= box_max.z;
      center_x      <= center.x;
      center_y      <= center.y;
      center_z      <= center.z;
      sphere_radius <= root;
    end
  end

`ifndef SYNTH
  // A last vertex without overflow starts the walk
  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && last_vertex && !ovf_now) |=> busy)
    else $error("walk did not start after last vertex");

  // A successful result frees the block in the same cycle
  a_free_after_result: assert property (@(posedge clk) disable iff (rst)
    (done && !status) |-> !busy)
    else $error("block still busy while showing a result");

  // Overflow results carry zero fields; radius, min_x and center_z are checked
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> ((sphere_radius == '0) && (min_x == '0) && (center_z == '0)))
    else $error("overflow result has nonzero fields");

  // Stored count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_BITS'(MAX_VERTICES))
    else $error("vertex count beyond store depth");
`endif

endmodule

@@ dv/mesh_bounds_and_sphere_top_tb.sv @@
// Testbench for mesh_bounds_and_sphere_top: random and directed meshes checked against a predictor.
module mesh_bounds_and_sphere_top_tb;
  import mbs_pkg::*;

  // Expected result of one mesh, held until done shows up
  typedef struct packed {
    logic                   status;
    coord_t                 min_x;
    coord_t                 min_y;
    coord_t                 min_z;
    coord_t                 max_x;
    coord_t                 max_y;
    coord_t                 max_z;
    coord_t                 center_x;
    coord_t                 center_y;
    coord_t                 center_z;
    logic [RADIUS_BITS-1:0] radius;
  } sphere_result_t;

  // Ways of drawing vertex coordinates for one mesh
  typedef enum int {
    PTS_FULL,     // anywhere in the coordinate range
    PTS_CLUSTER,  // within 4096 LSBs either side of a random base
    PTS_TIGHT,    // within a handful of LSBs of the base
    PTS_EXTREME   // corners of the range, zero and +/-1
  } point_style_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam int RANDOM_ITEMS  = 1630;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  coord_t                 x_coord = '0;
  coord_t                 y_coord = '0;
  coord_t                 z_coord = '0;
  logic                   last_vertex = 1'b0;
  logic                   done;
  logic                   status;
  coord_t                 min_x, min_y, min_z;
  coord_t                 max_x, max_y, max_z;
  coord_t                 center_x, center_y, center_z;
  logic [RADIUS_BITS-1:0] sphere_radius;

  // Predictor state: vertices of the mesh in flight, running box, overflow flag
  vertex_t        mesh_vertices[$];
  coord_t         box_lo[3];
  coord_t         box_hi[3];
  logic           mesh_overflow = 1'b0;
  sphere_result_t pending_spheres[$];

  int err_count  = 0;
  int items_sent = 0;

  mesh_bounds_and_sphere_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .last_vertex   (last_vertex),
    .done          (done),
    .status        (status),
    .min_x         (min_x),
    .min_y         (min_y),
    .min_z         (min_z),
    .max_x         (max_x),
    .max_y         (max_y),
    .max_z         (max_z),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  // One line per mismatch; printing stops after a while so a stuck strobe
  // cannot flood the log, but every mismatch is still counted.
  task automatic report_mismatch(string msg);
    if (err_count < 50) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Bit-by-bit floor square root: keep each result bit whose square still fits.
  function automatic logic [RADIUS_BITS-1:0] floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = RADIUS_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[RADIUS_BITS-1:0];
  endfunction

  // Folds one accepted vertex into the running mesh; on the last vertex it
  // walks the held vertices for the farthest one unless the mesh overflowed, and queues the result.
  task automatic fold_vertex(coord_t x, coord_t y, coord_t z, logic last);
    coord_t          p[3];
    coord_t          q[3];
    longint          mid[3];
    longint          diff;
    longint unsigned dist_sq;
    longint unsigned far_sq;
    logic            first;
    vertex_t         v;
    sphere_result_t  r;
    p = '{x, y, z};
    first = (mesh_vertices.size() == 0) && !mesh_overflow;
    for (int a = 0; a < 3; a++) begin
      if (first || p[a] < box_lo[a]) box_lo[a] = p[a];
      if (first || p[a] > box_hi[a]) box_hi[a] = p[a];
    end
    // A vertex beyond the store size still widens the box but is not held
    if (mesh_vertices.size() < MAX_VERTICES) begin
      v.x = x;
      v.y = y;
      v.z = z;
      mesh_vertices.push_back(v);
    end else begin
      mesh_overflow = 1'b1;
    end
    if (!last) return;

    r = '0;
    if (mesh_overflow) begin
      // Too many vertices: status set, every other field zero
      r.status = 1'b1;
    end else begin
      // Arithmetic shift gives the floor of the midpoint for negative sums too
      for (int a = 0; a < 3; a++) mid[a] = (longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1;
      far_sq = 0;
      foreach (mesh_vertices[i]) begin
        q = '{mesh_vertices[i].x, mesh_vertices[i].y, mesh_vertices[i].z};
        dist_sq = 0;
        for (int a = 0; a < 3; a++) begin
          diff = longint'(q[a]) - mid[a];
          dist_sq += longint'(diff * diff);
        end
        if (dist_sq > far_sq) far_sq = dist_sq;
      end
      r.min_x    = box_lo[0];
      r.min_y    = box_lo[1];
      r.min_z    = box_lo[2];
      r.max_x    = box_hi[0];
      r.max_y    = box_hi[1];
      r.max_z    = box_hi[2];
      r.center_x = coord_t'(mid[0]);
      r.center_y = coord_t'(mid[1]);
      r.center_z = coord_t'(mid[2]);
      r.radius   = floor_sqrt(far_sq);
    end
    pending_spheres.push_back(r);
    // Next mesh starts from an empty store and a cleared box
    mesh_vertices.delete();
    mesh_overflow = 1'b0;
    box_lo = '{default: '0};
    box_hi = '{default: '0};
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  // done is a one-cycle strobe that cannot be held off, so every rising edge
  // with done high is a result; compare it with the oldest expectation.
  always @(posedge clk) begin : result_check
    sphere_result_t want;
    if (!rst && done) begin
      if (pending_spheres.size() == 0) begin
        report_mismatch("result strobe with no mesh outstanding");
      end else begin
        want = pending_spheres.pop_front();
        check_field("status",        status,                 want.status);
        check_field("min_x",         longint'(min_x),        longint'(want.min_x));
        check_field("min_y",         longint'(min_y),        longint'(want.min_y));
        check_field("min_z",         longint'(min_z),        longint'(want.min_z));
        check_field("max_x",         longint'(max_x),        longint'(want.max_x));
        check_field("max_y",         longint'(max_y),        longint'(want.max_y));
        check_field("max_z",         longint'(max_z),        longint'(want.max_z));
        check_field("center_x",      longint'(center_x),     longint'(want.center_x));
        check_field("center_y",      longint'(center_y),     longint'(want.center_y));
        check_field("center_z",      longint'(center_z),     longint'(want.center_z));
        check_field("sphere_radius", longint'(sphere_radius), longint'(want.radius));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Idle cycles before an item: mostly none or a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one vertex from a falling edge, holds it until the block takes it
  // (start high, busy low at a rising edge), then drops start again.
  // Fields carry random noise during the idle gap before an item.
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last, int gap);
    if (gap > 0) begin
      start       = 1'b0;
      x_coord     = coord_t'($urandom);
      y_coord     = coord_t'($urandom);
      z_coord     = coord_t'($urandom);
      last_vertex = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    x_coord     = x;
    y_coord     = y;
    z_coord     = z;
    last_vertex = last;
    do @(posedge clk); while (busy);
    fold_vertex(x, y, z, last);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Sender holds off until every outstanding mesh result has come back
  task automatic wait_results_drained();
    while (pending_spheres.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic coord_t pick_coord(point_style_t style, coord_t base);
    case (style)
      PTS_CLUSTER: return base + coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
      PTS_TIGHT:   return base + coord_t'($urandom_range(0, 31)) - coord_t'(16);
      PTS_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          3:       return '1;
          default: return coord_t'(1);
        endcase
      end
      default:     return coord_t'($urandom);
    endcase
  endfunction

  // One mesh of n vertices in the given style; burst means no idle cycles
  task automatic run_mesh(int n, point_style_t style, bit burst);
    coord_t bx, by, bz;
    bx = coord_t'($urandom);
    by = coord_t'($urandom);
    bz = coord_t'($urandom);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(style, bx), pick_coord(style, by), pick_coord(style, bz),
                  i == n - 1, burst ? 0 : pick_gap());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Single-vertex meshes: box collapses to the point, radius zero
  task automatic test_single_vertex();
    send_vertex('0, '0, '0, 1'b1, 0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 0);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 2);
    send_vertex(COORD_MAX, COORD_MIN, '1, 1'b1, 0);
  endtask

  // Corner boxes, odd midpoint sums of both signs, repeated vertices
  task automatic test_box_extremes();
    // Full-range diagonal: largest possible radius, center at -1
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 0);
    // Mixed corners plus origin
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b0, 1);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(1), 1'b0, 0);
    send_vertex('0, '0, '0, 1'b1, 0);
    // Negative odd sum rounds down, positive odd sum rounds down
    send_vertex(coord_t'(-3), coord_t'(1), coord_t'(2), 1'b0, 0);
    send_vertex('0, coord_t'(2), coord_t'(3), 1'b1, 0);
    // Same vertex three times
    send_vertex(coord_t'(-5), coord_t'(7), coord_t'(-9), 1'b0, 0);
    send_vertex(coord_t'(-5), coord_t'(7), coord_t'(-9), 1'b0, 3);
    send_vertex(coord_t'(-5), coord_t'(7), coord_t'(-9), 1'b1, 0);
    // Pause with everything drained, then a mesh whose box grows at each step
    wait_results_drained();
    send_vertex(coord_t'(100), coord_t'(100), coord_t'(100), 1'b0, 0);
    send_vertex(coord_t'(-200), coord_t'(300), coord_t'(50), 1'b0, 0);
    send_vertex(coord_t'(400), coord_t'(-500), coord_t'(600), 1'b0, 0);
    send_vertex(COORD_MIN, coord_t'(10), COORD_MAX, 1'b1, 0);
  endtask

  // Random meshes: mostly small, some medium, a few 300 to 1000 vertices long;
  // the last mesh is cut so the item budget is met
  task automatic test_random_meshes();
    int           stop_at;
    int           r;
    int           n;
    point_style_t style;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60)      n = $urandom_range(1, 8);
      else if (r < 90) n = $urandom_range(9, 40);
      else if (r < 98) n = $urandom_range(41, 150);
      else             n = $urandom_range(300, 1000);
      if (n > stop_at - items_sent) n = stop_at - items_sent;
      style = point_style_t'($urandom_range(0, 3));
      run_mesh(n, style, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_single_vertex();
    test_box_extremes();
    test_random_meshes();
    // Last mesh walks its store before done; allow a margin once it is in
    wait_results_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("mesh_bounds_and_sphere_top_tb OK");
    end else begin
      $display("mesh_bounds_and_sphere_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1650 items with long
  // gaps plus the store walk and square root of each mesh)
  initial begin
    #50_000_000;
    $display("ERROR: timeout with %0d results outstanding", pending_spheres.size());
    $display("mesh_bounds_and_sphere_top_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mbs_pkg.sv
design/mbs_dist.sv
design/mbs_isqrt.sv
design/mesh_bounds_and_sphere_top.sv
dv/mesh_bounds_and_sphere_top_tb.sv
